// ===== rtl/cpr_pkg.sv =====
package cpr_pkg;

    // path mode codes as seen on path_state
    localparam logic [2:0] MODE_IDLE       = 3'd0;
    localparam logic [2:0] MODE_ANNIHILATE = 3'd1;
    localparam logic [2:0] MODE_A_WAIT     = 3'd2;
    localparam logic [2:0] MODE_A_RELAY    = 3'd3;
    localparam logic [2:0] MODE_B_WAIT     = 3'd4;
    localparam logic [2:0] MODE_B_RELAY    = 3'd5;

    localparam int unsigned ELAPSED_W = 16;
    localparam int unsigned STEPS_W   = 9;
    localparam int unsigned TIME_W    = 17;

    localparam logic signed [TIME_W-1:0] INACTIVE_TIME = '1;

    typedef struct packed {
        logic                        stimulate_a;
        logic                        stimulate_b;
        logic [2:0]                  path_state;
        logic signed [TIME_W-1:0]    active_time_a;
        logic signed [TIME_W-1:0]    active_time_b;
        logic [ELAPSED_W-1:0]        elapsed_ms_out;
        logic [STEPS_W-1:0]          progress_count;
    } t_result;

endpackage

// ===== rtl/cpr_if.sv =====
interface cpr_in_if;
    logic valid;
    logic ready;
    logic cell_a_active;
    logic cell_b_active;

    modport source (output valid, output cell_a_active, output cell_b_active, input ready);
    modport sink   (input valid, input cell_a_active, input cell_b_active, output ready);
endinterface

interface cpr_out_if;
    logic              valid;
    logic              ready;
    logic              stimulate_a;
    logic              stimulate_b;
    logic [2:0]        path_state;
    logic signed [16:0] active_time_a;
    logic signed [16:0] active_time_b;
    logic [15:0]       elapsed_ms_out;
    logic [8:0]        progress_count;

    modport source (
        output valid, output stimulate_a, output stimulate_b, output path_state,
        output active_time_a, output active_time_b, output elapsed_ms_out,
        output progress_count, input ready
    );
    modport sink (
        input valid, input stimulate_a, input stimulate_b, input path_state,
        input active_time_a, input active_time_b, input elapsed_ms_out,
        input progress_count, output ready
    );
endinterface

// ===== rtl/cpr_fsm.sv =====
module cpr_fsm import cpr_pkg::*; #(
    parameter int TIMESTEP_MS      = 200,
    parameter int DEFAULT_DELAY_MS = 1000
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_cell_a,
    input  logic                 i_cell_b,
    input  logic [ELAPSED_W-1:0] i_delay,
    output t_result              o_res
);

    typedef enum logic [2:0] {
        S_IDLE       = MODE_IDLE,
        S_ANNIHILATE = MODE_ANNIHILATE,
        S_A_WAIT     = MODE_A_WAIT,
        S_A_RELAY    = MODE_A_RELAY,
        S_B_WAIT     = MODE_B_WAIT,
        S_B_RELAY    = MODE_B_RELAY
    } t_state;

    localparam logic [ELAPSED_W+1:0] STEP1   = (ELAPSED_W+2)'(TIMESTEP_MS);
    localparam logic [ELAPSED_W+1:0] STEP2   = (ELAPSED_W+2)'(2 * TIMESTEP_MS);
    localparam logic [ELAPSED_W-1:0] DEF_DLY = ELAPSED_W'(DEFAULT_DELAY_MS);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [STEPS_W-1:0]   STEPS_MAX   = '1;
    localparam logic [STEPS_W-1:0]   STEPS_ONE   = STEPS_W'(1);

    t_state                   r_state, n_state;
    logic [ELAPSED_W-1:0]     r_elapsed, n_elapsed;
    logic [STEPS_W-1:0]       r_steps, n_steps;
    logic signed [TIME_W-1:0] r_side_a, n_side_a;
    logic signed [TIME_W-1:0] r_side_b, n_side_b;
    logic                     r_stim_a, n_stim_a;
    logic                     r_stim_b, n_stim_b;

    logic [ELAPSED_W+1:0] w_sum1;
    logic [ELAPSED_W+1:0] w_sum2;
    logic [ELAPSED_W-1:0] w_delay;
    logic [ELAPSED_W-1:0] w_elapsed_inc;
    logic [STEPS_W-1:0]   w_steps_inc;
    logic                 w_due;

    assign w_delay       = (i_delay != '0) ? i_delay : DEF_DLY;
    assign w_sum1        = {2'b00, r_elapsed} + STEP1;
    // elapsed plus two steps covers both the saturated and the one-step-ahead test
    assign w_sum2        = {2'b00, r_elapsed} + STEP2;
    assign w_elapsed_inc = (w_sum1[ELAPSED_W+1:ELAPSED_W] != 2'b00) ? ELAPSED_MAX
                                                                     : w_sum1[ELAPSED_W-1:0];
    assign w_steps_inc   = (r_steps != STEPS_MAX) ? r_steps + STEPS_ONE : r_steps;
    assign w_due         = w_sum2 >= {2'b00, w_delay};

    always_comb begin
        n_state   = r_state;
        n_elapsed = r_elapsed;
        n_steps   = r_steps;
        n_side_a  = r_side_a;
        n_side_b  = r_side_b;
        n_stim_a  = 1'b0;
        n_stim_b  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cell_a && i_cell_b) begin
                    n_steps = '0;
                    n_state = S_ANNIHILATE;
                end else if (i_cell_a) begin
                    n_elapsed = '0;
                    n_steps   = '0;
                    n_side_a  = '0;
                    n_side_b  = INACTIVE_TIME;
                    n_state   = S_A_WAIT;
                end else if (i_cell_b) begin
                    n_elapsed = '0;
                    n_steps   = '0;
                    n_side_a  = INACTIVE_TIME;
                    n_side_b  = '0;
                    n_state   = S_B_WAIT;
                end
            end
            S_ANNIHILATE: begin
                if (!i_cell_a && !i_cell_b) begin
                    n_state   = S_IDLE;
                    n_elapsed = '0;
                    n_steps   = '0;
                    n_side_a  = INACTIVE_TIME;
                    n_side_b  = INACTIVE_TIME;
                end
            end
            S_A_WAIT: begin
                n_elapsed = w_elapsed_inc;
                n_steps   = w_steps_inc;
                n_side_a  = {1'b0, w_elapsed_inc};
                if (w_due) begin
                    n_stim_b = 1'b1;
                    n_state  = S_A_RELAY;
                end
            end
            S_B_WAIT: begin
                n_elapsed = w_elapsed_inc;
                n_steps   = w_steps_inc;
                n_side_b  = {1'b0, w_elapsed_inc};
                if (w_due) begin
                    n_stim_a = 1'b1;
                    n_state  = S_B_RELAY;
                end
            end
            default: begin
                // relay states and unused codes
                n_state   = S_IDLE;
                n_elapsed = '0;
                n_steps   = '0;
                n_side_a  = INACTIVE_TIME;
                n_side_b  = INACTIVE_TIME;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_elapsed <= '0;
            r_steps   <= '0;
            r_side_a  <= INACTIVE_TIME;
            r_side_b  <= INACTIVE_TIME;
            r_stim_a  <= 1'b0;
            r_stim_b  <= 1'b0;
        end else if (i_step) begin
            r_state   <= n_state;
            r_elapsed <= n_elapsed;
            r_steps   <= n_steps;
            r_side_a  <= n_side_a;
            r_side_b  <= n_side_b;
            r_stim_a  <= n_stim_a;
            r_stim_b  <= n_stim_b;
        end
    end

    assign o_res.stimulate_a    = r_stim_a;
    assign o_res.stimulate_b    = r_stim_b;
    assign o_res.path_state     = r_state;
    assign o_res.active_time_a  = r_side_a;
    assign o_res.active_time_b  = r_side_b;
    assign o_res.elapsed_ms_out = r_elapsed;
    assign o_res.progress_count = r_steps;

endmodule

// ===== rtl/conduction_path_relay_fsm.sv =====
// channel   dir  handshake          payload
// i_in      in   valid/ready        cell_a_active, cell_b_active
// o_out     out  valid/ready        stimulate_a/b, path_state, active_time_a/b,
//                                   elapsed_ms_out, progress_count
// i_cfg_*   in   write enable only  relay_delay_ms
//
// one request per cycle sustained while the output is not stalled; from accept
// to result the request sits in an input register, then one pass through the
// path fsm loads the state and result register
// synchronous active-low reset: path idle, side times inactive, delay 0
// a stalled output holds its result while the input register can still fill
module conduction_path_relay_fsm import cpr_pkg::*; #(
    parameter int TIMESTEP_MS      = 200,
    parameter int DEFAULT_DELAY_MS = 1000
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [ELAPSED_W-1:0] i_cfg_wdata,
    cpr_in_if.sink               i_in,
    cpr_out_if.source            o_out
);

    logic [ELAPSED_W-1:0] r_delay;
    logic                 r_in_valid;
    logic                 r_cell_a;
    logic                 r_cell_b;
    logic                 r_out_valid;
    logic                 w_step;
    logic                 w_in_accept;
    t_result              w_res;

    assign w_step      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_step;
    assign w_in_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_delay <= i_cfg_wdata;
            end
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cell_a <= i_in.cell_a_active;
            r_cell_b <= i_in.cell_b_active;
        end
    end

    cpr_fsm #(
        .TIMESTEP_MS      (TIMESTEP_MS),
        .DEFAULT_DELAY_MS (DEFAULT_DELAY_MS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_cell_a (r_cell_a),
        .i_cell_b (r_cell_b),
        .i_delay  (r_delay),
        .o_res    (w_res)
    );

    assign o_out.valid          = r_out_valid;
    assign o_out.stimulate_a    = w_res.stimulate_a;
    assign o_out.stimulate_b    = w_res.stimulate_b;
    assign o_out.path_state     = w_res.path_state;
    assign o_out.active_time_a  = w_res.active_time_a;
    assign o_out.active_time_b  = w_res.active_time_b;
    assign o_out.elapsed_ms_out = w_res.elapsed_ms_out;
    assign o_out.progress_count = w_res.progress_count;

endmodule

// ===== rtl/cpr_checker.sv =====
module cpr_checker import cpr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_stim_a,
    input  logic                     i_stim_b,
    input  logic [2:0]               i_path_state,
    input  logic signed [TIME_W-1:0] i_time_a,
    input  logic [ELAPSED_W-1:0]     i_elapsed
);

    // nothing comes out in the cycle after reset
    ast_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a relay to cell b only shows together with the a-side relay state
    ast_stim_b_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_stim_b) |-> (i_path_state == MODE_A_RELAY && !i_stim_a))
        else $error("stimulate_b outside a-side relay");

    ast_stim_a_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_stim_a) |-> (i_path_state == MODE_B_RELAY && !i_stim_b))
        else $error("stimulate_a outside b-side relay");

    // during a b-side wait and its relay the a side stays unused
    ast_b_side_a_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_path_state == MODE_B_WAIT || i_path_state == MODE_B_RELAY))
        |-> (i_time_a == INACTIVE_TIME))
        else $error("a-side time set during b-side wait");

    ast_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_path_state) && $stable(i_elapsed)))
        else $error("stalled result changed");

endmodule

bind conduction_path_relay_fsm cpr_checker u_cpr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_stim_a     (o_out.stimulate_a),
    .i_stim_b     (o_out.stimulate_b),
    .i_path_state (o_out.path_state),
    .i_time_a     (o_out.active_time_a),
    .i_elapsed    (o_out.elapsed_ms_out)
);

// ===== bench/tb.sv =====
module tb;
    import cpr_pkg::*;

    localparam int TIMESTEP_MS      = 200;
    localparam int DEFAULT_DELAY_MS = 1000;
    localparam int STALL_LIMIT      = 2000;
    localparam int HOLD_CYCLES      = 120;

    typedef struct packed {
        logic cell_a;
        logic cell_b;
    } t_tick;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [ELAPSED_W-1:0] cfg_wdata;

    cpr_in_if  in_ch ();
    cpr_out_if out_ch ();

    conduction_path_relay_fsm #(
        .TIMESTEP_MS      (TIMESTEP_MS),
        .DEFAULT_DELAY_MS (DEFAULT_DELAY_MS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // path model state
    logic [2:0]              path_q;
    logic [ELAPSED_W-1:0]    elapsed_q;
    logic [STEPS_W-1:0]      steps_q;
    logic signed [TIME_W-1:0] time_a_q;
    logic signed [TIME_W-1:0] time_b_q;
    logic [ELAPSED_W-1:0]    delay_q;

    t_tick   pending_ticks[$];
    t_result expected_results[$];

    logic tick_taken;
    bit   steady;
    int   hold_reqs;
    int   hold_served;
    int   hold_left;
    int   mismatches;
    int   stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_path();
        path_q    = MODE_IDLE;
        elapsed_q = '0;
        steps_q   = '0;
        time_a_q  = INACTIVE_TIME;
        time_b_q  = INACTIVE_TIME;
    endfunction

    // one wait tick; true when the relay pulse is due
    function automatic bit take_wait_step();
        int unsigned eff;
        int unsigned sum;
        eff = (delay_q != '0) ? int'(delay_q) : DEFAULT_DELAY_MS;
        sum = elapsed_q + TIMESTEP_MS;
        if (sum > 65535) sum = 65535;
        elapsed_q = sum[ELAPSED_W-1:0];
        if (steps_q != '1) steps_q = steps_q + 1'b1;
        return (sum >= eff) || (TIMESTEP_MS >= eff - sum);
    endfunction

    function automatic t_result advance_path(logic cell_a, logic cell_b);
        t_result r;
        r = '0;
        case (path_q)
            MODE_IDLE: begin
                if (cell_a && cell_b) begin
                    steps_q = '0;
                    path_q  = MODE_ANNIHILATE;
                end else if (cell_a) begin
                    elapsed_q = '0;
                    steps_q   = '0;
                    time_a_q  = '0;
                    time_b_q  = INACTIVE_TIME;
                    path_q    = MODE_A_WAIT;
                end else if (cell_b) begin
                    elapsed_q = '0;
                    steps_q   = '0;
                    time_a_q  = INACTIVE_TIME;
                    time_b_q  = '0;
                    path_q    = MODE_B_WAIT;
                end
            end
            MODE_ANNIHILATE: begin
                if (!cell_a && !cell_b) clear_path();
            end
            MODE_A_WAIT: begin
                if (take_wait_step()) begin
                    r.stimulate_b = 1'b1;
                    path_q        = MODE_A_RELAY;
                end
                time_a_q = {1'b0, elapsed_q};
            end
            MODE_B_WAIT: begin
                if (take_wait_step()) begin
                    r.stimulate_a = 1'b1;
                    path_q        = MODE_B_RELAY;
                end
                time_b_q = {1'b0, elapsed_q};
            end
            default: clear_path();
        endcase
        r.path_state     = path_q;
        r.active_time_a  = time_a_q;
        r.active_time_b  = time_b_q;
        r.elapsed_ms_out = elapsed_q;
        r.progress_count = steps_q;
        return r;
    endfunction

    // accepted requests feed the model, accepted results are checked
    always @(posedge i_clk) begin : track_results
        t_result want;
        tick_taken <= in_ch.valid && in_ch.ready;
        if (in_ch.valid && in_ch.ready)
            expected_results.push_back(advance_path(in_ch.cell_a_active, in_ch.cell_b_active));
        if (out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (out_ch.stimulate_a !== want.stimulate_a) begin
                    $error("stimulate_a: expected %0d, got %0d",
                           want.stimulate_a, out_ch.stimulate_a);
                    mismatches++;
                end
                if (out_ch.stimulate_b !== want.stimulate_b) begin
                    $error("stimulate_b: expected %0d, got %0d",
                           want.stimulate_b, out_ch.stimulate_b);
                    mismatches++;
                end
                if (out_ch.path_state !== want.path_state) begin
                    $error("path_state: expected %0d, got %0d",
                           want.path_state, out_ch.path_state);
                    mismatches++;
                end
                if (out_ch.active_time_a !== want.active_time_a) begin
                    $error("active_time_a: expected %0d, got %0d",
                           want.active_time_a, out_ch.active_time_a);
                    mismatches++;
                end
                if (out_ch.active_time_b !== want.active_time_b) begin
                    $error("active_time_b: expected %0d, got %0d",
                           want.active_time_b, out_ch.active_time_b);
                    mismatches++;
                end
                if (out_ch.elapsed_ms_out !== want.elapsed_ms_out) begin
                    $error("elapsed_ms_out: expected %0d, got %0d",
                           want.elapsed_ms_out, out_ch.elapsed_ms_out);
                    mismatches++;
                end
                if (out_ch.progress_count !== want.progress_count) begin
                    $error("progress_count: expected %0d, got %0d",
                           want.progress_count, out_ch.progress_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    always @(negedge i_clk) begin : drive_ticks
        t_tick nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || tick_taken) begin
            if (pending_ticks.size() > 0 && (steady || $urandom_range(99) >= 9)) begin
                nxt = pending_ticks.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.cell_a_active <= nxt.cell_a;
                in_ch.cell_b_active <= nxt.cell_b;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_reqs != hold_served) begin
            hold_served  <= hold_reqs;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    task automatic queue_tick(logic cell_a, logic cell_b);
        pending_ticks.push_back('{cell_a: cell_a, cell_b: cell_b});
    endtask

    // mostly single-cell starts so waits and relays dominate
    task automatic queue_random_ticks(int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 35)      queue_tick(1'b1, 1'b0);
            else if (pick < 70) queue_tick(1'b0, 1'b1);
            else if (pick < 85) queue_tick(1'b1, 1'b1);
            else                queue_tick(1'b0, 1'b0);
        end
    endtask

    task automatic wait_quiet();
        while (pending_ticks.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic program_delay(logic [ELAPSED_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we  <= 1'b0;
        delay_q = value;
    endtask

    task automatic run_phase(logic [ELAPSED_W-1:0] value, int count, bit calm, bit squeeze);
        wait_quiet();
        program_delay(value);
        steady = calm;
        queue_random_ticks(count);
        if (squeeze) begin
            repeat (30) @(posedge i_clk);
            hold_reqs++;
        end
        wait_quiet();
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        in_ch.valid         = 1'b0;
        in_ch.cell_a_active = 1'b0;
        in_ch.cell_b_active = 1'b0;
        out_ch.ready        = 1'b0;
        tick_taken          = 1'b0;
        steady              = 1'b0;
        hold_reqs           = 0;
        hold_served         = 0;
        hold_left           = 0;
        mismatches          = 0;
        stall_cycles        = 0;
        delay_q             = '0;
        clear_path();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default delay: quiet, annihilate and its exit, then a full relay each way
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        wait_quiet();

        // shortest delay fires on the first wait tick
        program_delay(16'd1);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        wait_quiet();

        // start a long wait, then lower the delay below the elapsed time
        program_delay(16'hFFFF);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b0);
        wait_quiet();
        program_delay(16'd200);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b0);

        run_phase(16'd0, 155, 1'b0, 1'b0);
        run_phase(16'd1, 155, 1'b0, 1'b0);
        run_phase(16'd200, 155, 1'b0, 1'b0);
        run_phase(16'd201, 155, 1'b0, 1'b0);
        run_phase(16'd400, 155, 1'b1, 1'b0);
        run_phase(16'hFFFF, 350, 1'b0, 1'b0);
        run_phase(16'($urandom_range(1, 3000)), 155, 1'b0, 1'b0);
        run_phase(16'($urandom_range(1, 3000)), 155, 1'b0, 1'b0);
        run_phase(16'd1000, 155, 1'b0, 1'b1);
        run_phase(16'd0, 155, 1'b0, 1'b0);

        wait_quiet();
        repeat (5) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
